// ===== hw/rtl/shift_and_add_backprojection_unit_defines.svh =====
// Assertion macros for the backprojection unit.
`ifndef SHIFT_AND_ADD_BACKPROJECTION_UNIT_DEFINES_SVH
`define SHIFT_AND_ADD_BACKPROJECTION_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SAB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SAB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SAB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SAB_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/sab_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sab_pkg;

    localparam int CMD_W       = 1;
    localparam int PROJ_W      = 4;
    localparam int COORD_W     = 10;
    localparam int PIXEL_W     = 16;
    localparam int SUM_W       = 21;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int SLICE_W     = 8;
    localparam int LEVEL_W     = 8;
    localparam int TILT_W      = 16;
    localparam int B_W         = 16;
    localparam int R_W         = 18;
    localparam int TRIG_W      = 10;
    localparam int PROD_W      = 28;
    localparam int ACC_W       = 28;
    localparam int POS_W       = 11;

    localparam logic [CMD_W-1:0] CMD_ACCUM = 1'b0;
    localparam logic [CMD_W-1:0] CMD_READ  = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_SLICE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LEVELS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TILT   = 2'd2;

    localparam logic [SLICE_W-1:0] SLICE_RESET  = 8'd0;
    localparam logic [LEVEL_W-1:0] LEVELS_RESET = 8'd200;
    localparam logic [TILT_W-1:0]  TILT_RESET   = 16'd37590;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 21'sd1048575;
    localparam logic signed [SUM_W-1:0] SUM_MIN = -21'sd1048576;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MULT,
        ST_ADDR,
        ST_READ,
        ST_MODIFY
    } sab_state_t;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } sab_target_t;

    function automatic logic signed [TRIG_W-1:0] cos_q8(input logic [PROJ_W-1:0] k);
        logic signed [TRIG_W-1:0] v;
        case (k)
            4'd0:    v = 10'sd256;
            4'd1:    v = 10'sd237;
            4'd2:    v = 10'sd181;
            4'd3:    v = 10'sd98;
            4'd4:    v = 10'sd0;
            4'd5:    v = -10'sd98;
            4'd6:    v = -10'sd181;
            4'd7:    v = -10'sd237;
            4'd8:    v = -10'sd256;
            4'd9:    v = -10'sd237;
            4'd10:   v = -10'sd181;
            4'd11:   v = -10'sd98;
            4'd12:   v = 10'sd0;
            4'd13:   v = 10'sd98;
            4'd14:   v = 10'sd181;
            default: v = 10'sd237;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sab_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sab_request_if import sab_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic [PROJ_W-1:0]         projection_number;
    logic [COORD_W-1:0]        row;
    logic [COORD_W-1:0]        column;
    logic signed [PIXEL_W-1:0] pixel;

    modport source (output valid, command, projection_number, row, column, pixel,
                    input ready);
    modport sink   (input valid, command, projection_number, row, column, pixel,
                    output ready);
endinterface

interface sab_response_if import sab_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] sum;

    modport source (output valid, sum, input ready);
    modport sink   (input valid, sum, output ready);
endinterface

interface sab_setup_if import sab_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sab_shift.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sab_shift import sab_pkg::*; #(
    parameter int OUT_SIZE = 1024
) (
    input  wire logic               clk,
    input  wire logic [SLICE_W-1:0] slice_index,
    input  wire logic [LEVEL_W-1:0] level_count,
    input  wire logic [TILT_W-1:0]  tilt_sine,
    input  wire logic [PROJ_W-1:0]  projection_number,
    input  wire logic [COORD_W-1:0] row,
    input  wire logic [COORD_W-1:0] column,
    output sab_target_t             target
);

    logic signed [LEVEL_W:0]     depth;
    logic signed [25:0]          r_prod;
    logic signed [25:0]          r_round;
    logic [23:0]                 b_prod;
    logic [23:0]                 b_round;
    logic [B_W-1:0]              b_reg;
    logic signed [R_W-1:0]       r_reg;
    logic signed [TRIG_W-1:0]    cos_v;
    logic signed [TRIG_W-1:0]    sin_v;
    logic signed [PROD_W-1:0]    prod_c_reg;
    logic signed [PROD_W-1:0]    prod_s_reg;
    logic signed [ACC_W-1:0]     x_sum;
    logic signed [ACC_W-1:0]     y_sum;
    logic [ACC_W-17:0]           x_full;
    logic [ACC_W-17:0]           y_full;

    // base and depth shifts in Q8, rounded half up
    assign depth   = $signed({1'b0, level_count}) - $signed({1'b0, slice_index});
    assign r_prod  = 26'(depth) * 26'($signed({1'b0, tilt_sine}));
    assign r_round = r_prod + 26'sd128;
    assign b_prod  = 24'(level_count) * 24'(tilt_sine);
    assign b_round = b_prod + 24'd128;

    assign cos_v = cos_q8(projection_number);
    assign sin_v = cos_q8(projection_number + 4'd12);

    always_ff @(posedge clk)
    begin
        b_reg      <= b_round[23:8];
        r_reg      <= r_round[25:8];
        prod_c_reg <= PROD_W'(r_reg) * PROD_W'(cos_v);
        prod_s_reg <= PROD_W'(r_reg) * PROD_W'(sin_v);
    end

    assign x_sum = $signed({2'b0, column, 16'b0}) + $signed({4'b0, b_reg, 8'b0})
                 + prod_c_reg + 28'sd32768;
    assign y_sum = $signed({2'b0, row, 16'b0}) + $signed({4'b0, b_reg, 8'b0})
                 - prod_s_reg + 28'sd32768;

    assign x_full = x_sum[ACC_W-1:16];
    assign y_full = y_sum[ACC_W-1:16];

    assign target.x   = x_full[POS_W-1:0];
    assign target.y   = y_full[POS_W-1:0];
    assign target.hit = !x_full[ACC_W-17] && !y_full[ACC_W-17]
                     && (32'(x_full[POS_W-1:0]) < 32'(OUT_SIZE))
                     && (32'(y_full[POS_W-1:0]) < 32'(OUT_SIZE));

endmodule

`default_nettype wire

// ===== hw/rtl/shift_and_add_backprojection_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shift-and-add backprojection of one slice into an OUT_SIZE x OUT_SIZE store
// of 21-bit saturating sums. After reset the block sweeps the store to zero,
// one entry per cycle, with request.ready low; setup writes are always taken.
// An accumulate item passes accept, shift multiply, target add, store read
// and store write; a read-and-clear item passes accept, store read and store
// write. The single store is read and written back in turn, so one item is
// in flight at a time. Accumulate items whose source or target lies off the
// grid are dropped, at accept or after the target add; an off-grid read
// returns zero. A finished read result waits in the response register while
// the next item is taken. Sums are not scaled by the level count.
module shift_and_add_backprojection_unit import sab_pkg::*; #(
    parameter int IN_SIZE     = 1024,
    parameter int OUT_SIZE    = 1024,
    parameter int PROJECTIONS = 16
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    sab_request_if.sink    request,
    sab_response_if.source response,
    sab_setup_if.sink      setup
);

`include "shift_and_add_backprojection_unit_defines.svh"

    localparam int DEPTH  = OUT_SIZE * OUT_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);

    sab_state_t state_reg;
    sab_state_t state_next;

    logic [SLICE_W-1:0]        slice_reg;
    logic [LEVEL_W-1:0]        levels_reg;
    logic [TILT_W-1:0]         tilt_reg;

    logic [CMD_W-1:0]          cmd_reg;
    logic [PROJ_W-1:0]         proj_reg;
    logic [COORD_W-1:0]        row_reg;
    logic [COORD_W-1:0]        col_reg;
    logic signed [PIXEL_W-1:0] pixel_reg;
    logic [POS_W-1:0]          x_reg;
    logic [POS_W-1:0]          y_reg;
    logic                      hit_reg;

    logic [ADDR_W-1:0]         clr_cnt_reg;
    logic                      clr_last;

    logic signed [SUM_W-1:0]   store_mem [DEPTH];
    logic signed [SUM_W-1:0]   rd_data_reg;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr;
    logic signed [SUM_W-1:0]   mem_wdata;

    logic signed [SUM_W:0]     acc_sum;
    logic signed [SUM_W-1:0]   acc_sat;

    logic                      out_valid_reg;
    logic signed [SUM_W-1:0]   out_sum_reg;
    logic                      out_load;

    logic                      cfg_fire;
    logic                      accept;
    logic                      acc_ok;
    logic                      rd_ok;
    logic                      advance;
    sab_target_t               target;

    assign cfg_fire    = setup.valid && setup.ready;
    assign setup.ready = 1'b1;

    assign request.ready = (state_reg == ST_IDLE) && !cfg_fire;
    assign accept        = request.valid && request.ready;

    assign acc_ok = (32'(request.row) < 32'(IN_SIZE))
                 && (32'(request.column) < 32'(IN_SIZE))
                 && (32'(request.projection_number) < 32'(PROJECTIONS));
    assign rd_ok  = (32'(request.row) < 32'(OUT_SIZE))
                 && (32'(request.column) < 32'(OUT_SIZE));

    assign clr_last = (clr_cnt_reg == ADDR_W'(DEPTH - 1));

    assign advance  = (cmd_reg != CMD_READ) || !out_valid_reg || response.ready;
    assign out_load = (state_reg == ST_MODIFY) && (cmd_reg == CMD_READ) && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_reg  <= SLICE_RESET;
            levels_reg <= LEVELS_RESET;
            tilt_reg   <= TILT_RESET;
        end
        else if (cfg_fire)
        begin
            unique case (setup.index)
                REG_SLICE:  slice_reg  <= setup.data[SLICE_W-1:0];
                REG_LEVELS: levels_reg <= setup.data[LEVEL_W-1:0];
                REG_TILT:   tilt_reg   <= setup.data[TILT_W-1:0];
                default:    ;
            endcase
        end
    end

    sab_shift #(
        .OUT_SIZE (OUT_SIZE)
    ) u_shift (
        .clk               (clk),
        .slice_index       (slice_reg),
        .level_count       (levels_reg),
        .tilt_sine         (tilt_reg),
        .projection_number (proj_reg),
        .row               (row_reg),
        .column            (col_reg),
        .target            (target)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (request.command == CMD_READ)
                        state_next = ST_READ;
                    else if (acc_ok)
                        state_next = ST_MULT;
                end
            end
            ST_MULT:   state_next = ST_ADDR;
            ST_ADDR:   state_next = target.hit ? ST_READ : ST_IDLE;
            ST_READ:   state_next = ST_MODIFY;
            ST_MODIFY:
            begin
                if (advance)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= request.command;
            proj_reg  <= request.projection_number;
            row_reg   <= request.row;
            col_reg   <= request.column;
            pixel_reg <= request.pixel;
            x_reg     <= POS_W'(request.column);
            y_reg     <= POS_W'(request.row);
            hit_reg   <= rd_ok;
        end
        else if (state_reg == ST_ADDR)
        begin
            x_reg   <= target.x;
            y_reg   <= target.y;
            hit_reg <= target.hit;
        end
    end

    assign rd_addr = ADDR_W'(32'(y_reg) * 32'(OUT_SIZE) + 32'(x_reg));

    // saturating accumulate
    assign acc_sum = {rd_data_reg[SUM_W-1], rd_data_reg}
                   + (SUM_W + 1)'(pixel_reg);
    always_comb
    begin
        if (acc_sum[SUM_W] != acc_sum[SUM_W-1])
            acc_sat = acc_sum[SUM_W] ? SUM_MIN : SUM_MAX;
        else
            acc_sat = acc_sum[SUM_W-1:0];
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = rd_addr;
        mem_wdata = '0;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
        end
        else if ((state_reg == ST_MODIFY) && advance && hit_reg)
        begin
            mem_we    = 1'b1;
            mem_wdata = (cmd_reg == CMD_READ) ? '0 : acc_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_waddr] <= mem_wdata;
        if (state_reg == ST_READ)
            rd_data_reg <= store_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (response.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_sum_reg <= hit_reg ? rd_data_reg : '0;
    end

    assign response.valid = out_valid_reg;
    assign response.sum   = out_sum_reg;

    `SAB_ASSERT_IMP(a_no_accept_in_clear, clk, rst_n,
        state_reg == ST_CLEAR, !request.ready)
    `SAB_ASSERT_IMP(a_miss_never_writes, clk, rst_n,
        (state_reg == ST_MODIFY) && !hit_reg, !mem_we)
    `SAB_ASSERT_NXT(a_result_presented, clk, rst_n,
        out_load, response.valid)

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import sab_pkg::*;

    localparam int IN_SIZE        = 1024;
    localparam int OUT_SIZE       = 1024;
    localparam int PROJECTIONS    = 16;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 4 * OUT_SIZE * OUT_SIZE;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic [PROJ_W-1:0]         projection_number;
        logic [COORD_W-1:0]        row;
        logic [COORD_W-1:0]        column;
        logic signed [PIXEL_W-1:0] pixel;
    } bp_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] column;
    } grid_spot_t;

    logic clk;
    logic rst_n;

    sab_request_if  request_ch ();
    sab_response_if response_ch ();
    sab_setup_if    setup_ch ();

    shift_and_add_backprojection_unit #(
        .IN_SIZE     (IN_SIZE),
        .OUT_SIZE    (OUT_SIZE),
        .PROJECTIONS (PROJECTIONS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_ch),
        .response (response_ch),
        .setup    (setup_ch)
    );

    int cos_table [16] = '{256, 237, 181, 98, 0, -98, -181, -237,
                           -256, -237, -181, -98, 0, 98, 181, 237};

    logic [SLICE_W-1:0] slice_cfg = SLICE_RESET;
    logic [LEVEL_W-1:0] level_cfg = LEVELS_RESET;
    logic [TILT_W-1:0]  tilt_cfg  = TILT_RESET;

    logic signed [SUM_W-1:0] slice_sums [int];
    logic signed [SUM_W-1:0] read_sums [$];
    logic signed [SUM_W-1:0] expected_sum;
    bp_item_t                pending_items [$];
    bp_item_t                next_item;
    grid_spot_t              hot_spots [$];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  errors         = 0;
    int  stalled_cycles = 0;
    bit  req_taken      = 1'b0;
    bit  setup_taken;
    bit  sum_taken;

    always #1 clk = ~clk;

    function automatic void shift_target(input logic [PROJ_W-1:0] proj,
                                         input logic [COORD_W-1:0] row,
                                         input logic [COORD_W-1:0] column,
                                         output bit hit, output longint x, output longint y);
        longint base, depth_shift, c, s;
        base        = (longint'(level_cfg) * longint'(tilt_cfg) + 128) >>> 8;
        depth_shift = ((longint'(level_cfg) - longint'(slice_cfg)) * longint'(tilt_cfg) + 128)
                      >>> 8;
        c = cos_table[proj];
        s = cos_table[4'(proj + 4'd12)];
        x = (longint'(column) * 65536 + base * 256 + depth_shift * c + 32768) >>> 16;
        y = (longint'(row) * 65536 + base * 256 - depth_shift * s + 32768) >>> 16;
        hit = int'(proj) < PROJECTIONS && int'(row) < IN_SIZE && int'(column) < IN_SIZE
              && x >= 0 && x < OUT_SIZE && y >= 0 && y < OUT_SIZE;
    endfunction

    function automatic void predict_item(input bp_item_t it);
        bit                        hit;
        longint                    x, y;
        int                        addr;
        int                        acc;
        logic signed [PIXEL_W-1:0] addend;
        logic signed [SUM_W-1:0]   held;
        if (it.command == CMD_READ)
        begin
            held = '0;
            if (int'(it.row) < OUT_SIZE && int'(it.column) < OUT_SIZE)
            begin
                addr = int'(it.row) * OUT_SIZE + int'(it.column);
                if (slice_sums.exists(addr))
                    held = slice_sums[addr];
                slice_sums.delete(addr);
            end
            read_sums = {read_sums, held};
        end
        else
        begin
            shift_target(it.projection_number, it.row, it.column, hit, x, y);
            if (hit)
            begin
                addr   = int'(y) * OUT_SIZE + int'(x);
                addend = it.pixel;
                acc    = addend;
                if (slice_sums.exists(addr))
                    acc += slice_sums[addr];
                if (acc > SUM_MAX)
                    acc = SUM_MAX;
                if (acc < SUM_MIN)
                    acc = SUM_MIN;
                slice_sums[addr] = acc[SUM_W-1:0];
            end
        end
    endfunction

    function automatic void queue_accumulate(input logic [PROJ_W-1:0] proj,
                                             input logic [COORD_W-1:0] row,
                                             input logic [COORD_W-1:0] column,
                                             input logic [PIXEL_W-1:0] pixel);
        bp_item_t   it;
        grid_spot_t spot;
        bit         hit;
        longint     x, y;
        it.command           = CMD_ACCUM;
        it.projection_number = proj;
        it.row               = row;
        it.column            = column;
        it.pixel             = pixel;
        pending_items = {pending_items, it};
        shift_target(proj, row, column, hit, x, y);
        if (hit)
        begin
            spot.row    = COORD_W'(y);
            spot.column = COORD_W'(x);
            hot_spots = {hot_spots, spot};
            if (hot_spots.size() > 64)
                void'(hot_spots.pop_front());
        end
    endfunction

    function automatic void queue_read(input logic [COORD_W-1:0] row,
                                       input logic [COORD_W-1:0] column);
        bp_item_t it;
        it.command           = CMD_READ;
        it.projection_number = PROJ_W'($urandom);
        it.row               = row;
        it.column            = column;
        it.pixel             = PIXEL_W'($urandom);
        pending_items = {pending_items, it};
    endfunction

    task automatic random_items(input int quota);
        int                        produced;
        int                        burst;
        bit                        saturate;
        bit                        negative;
        bit                        hit;
        longint                    x, y;
        logic [PROJ_W-1:0]         proj;
        logic [COORD_W-1:0]        row, column;
        logic [PIXEL_W-1:0]        pixel;
        grid_spot_t                spot;
        int                        roll;
        produced = 0;
        while (produced < quota)
        begin
            roll = $urandom_range(99);
            if (roll < 60)
            begin
                proj     = PROJ_W'($urandom);
                row      = COORD_W'($urandom);
                column   = COORD_W'($urandom);
                saturate = ($urandom_range(99) < 5);
                negative = 1'($urandom_range(1));
                burst    = saturate ? $urandom_range(33, 40) : $urandom_range(1, 6);
                repeat (burst)
                begin
                    if (saturate)
                        pixel = negative ? 16'h8000 + PIXEL_W'($urandom_range(255))
                                         : 16'h7fff - PIXEL_W'($urandom_range(255));
                    else
                        pixel = PIXEL_W'($urandom);
                    queue_accumulate(proj, row, column, pixel);
                end
                produced += burst;
                shift_target(proj, row, column, hit, x, y);
                if (hit)
                begin
                    queue_read(COORD_W'(y), COORD_W'(x));
                    produced++;
                    if ($urandom_range(3) == 0)
                    begin
                        queue_read(COORD_W'(y), COORD_W'(x));
                        produced++;
                    end
                end
            end
            else if (roll < 80)
            begin
                queue_accumulate(PROJ_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                                 PIXEL_W'($urandom));
                produced++;
            end
            else
            begin
                if (hot_spots.size() > 0 && $urandom_range(1))
                begin
                    spot = hot_spots[$urandom_range(hot_spots.size() - 1)];
                    queue_read(spot.row, spot.column);
                end
                else
                    queue_read(COORD_W'($urandom), COORD_W'($urandom));
                produced++;
            end
        end
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        setup_ch.valid <= 1'b1;
        setup_ch.index <= index;
        setup_ch.data  <= value;
        do
            @(posedge clk);
        while (!setup_ch.ready);
        @(negedge clk);
    endtask

    task automatic configure(input int slice, input int levels, input int tilt,
                             input bit touch_spare);
        @(negedge clk);
        write_register(REG_SLICE, {8'($urandom), 8'(slice)});
        write_register(REG_LEVELS, {8'($urandom), 8'(levels)});
        write_register(REG_TILT, 16'(tilt));
        if (touch_spare)
            write_register(REG_SPARE, 16'($urandom));
        setup_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || request_ch.valid)
            @(posedge clk);
        while (read_sums.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // hold the item until taken, then advance or idle
    always @(negedge clk)
    begin
        if (!rst_n)
            request_ch.valid <= 1'b0;
        else if (!request_ch.valid || req_taken)
        begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_item = pending_items.pop_front();
                request_ch.valid             <= 1'b1;
                request_ch.command           <= next_item.command;
                request_ch.projection_number <= next_item.projection_number;
                request_ch.row               <= next_item.row;
                request_ch.column            <= next_item.column;
                request_ch.pixel             <= next_item.pixel;
            end
            else
                request_ch.valid <= 1'b0;
        end
        response_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        req_taken   = rst_n && request_ch.valid && request_ch.ready;
        setup_taken = rst_n && setup_ch.valid && setup_ch.ready;
        sum_taken   = rst_n && response_ch.valid && response_ch.ready;
        if (setup_taken)
        begin
            case (setup_ch.index)
                REG_SLICE:  slice_cfg = setup_ch.data[SLICE_W-1:0];
                REG_LEVELS: level_cfg = setup_ch.data[LEVEL_W-1:0];
                REG_TILT:   tilt_cfg  = setup_ch.data[TILT_W-1:0];
                default:    ;
            endcase
        end
        if (req_taken)
            predict_item({request_ch.command, request_ch.projection_number, request_ch.row,
                          request_ch.column, request_ch.pixel});
        if (sum_taken)
        begin
            if (read_sums.size() == 0)
            begin
                $error("sum: expected none, actual %0d", response_ch.sum);
                errors++;
            end
            else
            begin
                expected_sum = read_sums.pop_front();
                if (response_ch.sum !== expected_sum)
                begin
                    $error("sum: expected %0d, actual %0d", expected_sum, response_ch.sum);
                    errors++;
                end
            end
        end
        if (req_taken || setup_taken || sum_taken)
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        int k;
        clk                          = 1'b0;
        rst_n                        = 1'b0;
        request_ch.valid             = 1'b0;
        request_ch.command           = CMD_ACCUM;
        request_ch.projection_number = '0;
        request_ch.row               = '0;
        request_ch.column            = '0;
        request_ch.pixel             = '0;
        response_ch.ready            = 1'b0;
        setup_ch.valid               = 1'b0;
        setup_ch.index               = REG_SLICE;
        setup_ch.data                = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // every projection, grid corners and edges, extreme samples
        for (k = 0; k < 16; k++)
            queue_accumulate(PROJ_W'(k),
                             (k % 3 == 0) ? 10'd0 : (k % 3 == 1) ? 10'd1023 : 10'd512,
                             (k & 2) ? 10'd1023 : 10'd0,
                             (k & 1) ? 16'h8000 : 16'h7fff);
        for (k = 0; k < 4 && k < hot_spots.size(); k++)
            queue_read(hot_spots[k].row, hot_spots[k].column);
        queue_read(10'd0, 10'd0);
        queue_read(10'd1023, 10'd1023);
        random_items(75);
        drain();

        configure(0, 255, 65535, 1'b0);
        send_idle_pct  = 72;
        recv_stall_pct = 0;
        random_items(85);
        drain();

        // slice beyond level count: negative depth shift
        configure(255, 1, 65535, 1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 72;
        random_items(85);
        drain();

        configure(7, 0, 50000, 1'b1);
        send_idle_pct  = 22;
        recv_stall_pct = 22;
        random_items(85);
        drain();

        configure(128, 200, 0, 1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_items(85);
        drain();

        configure($urandom_range(255), $urandom_range(255), $urandom_range(65535), 1'b0);
        send_idle_pct  = 72;
        recv_stall_pct = 0;
        random_items(85);
        drain();

        configure(100, 200, 37590, 1'b1);
        send_idle_pct  = 22;
        recv_stall_pct = 22;
        random_items(85);
        drain();

        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
